>>> rtl/core/obbw_pkg.sv
`default_nettype none

package obbw_pkg;

  // Fixed-point formats of the packed fields.
  localparam int POS_WIDTH   = 20;
  localparam int AXIS_WIDTH  = 16;
  localparam int POS_FRAC    = POS_WIDTH / 2;
  localparam int AXIS_FRAC   = AXIS_WIDTH - 2;
  localparam int NUM_DIMS    = 3;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_EDGES   = 12;
  localparam int NUM_PAIRS   = 4;

  // Packed field widths.
  localparam int POS_VEC_W  = NUM_DIMS * POS_WIDTH;
  localparam int AXIS_VEC_W = NUM_DIMS * AXIS_WIDTH;
  localparam int COLOR_W    = 32;
  localparam int EDGE_W     = 4;
  localparam int CORNER_IDX_W = 3;
  localparam int PAIR_IDX_W   = 2;

  // Internal arithmetic widths: a product, an exact corner sum and its rounded form.
  localparam int PROD_W = POS_WIDTH + AXIS_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - AXIS_FRAC;

  typedef logic signed [POS_WIDTH-1:0]  pos_t;
  typedef logic signed [AXIS_WIDTH-1:0] axis_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [RND_W-1:0]      rnd_t;
  typedef logic [POS_VEC_W-1:0]         corner_t;
  typedef logic [EDGE_W-1:0]            edge_t;
  typedef logic [CORNER_IDX_W-1:0]      corner_idx_t;
  typedef logic [PAIR_IDX_W-1:0]        pair_idx_t;
  typedef corner_t [NUM_CORNERS-1:0]    corner_arr_t;

  // Eight corners of one box together with its color.
  typedef struct packed {
    corner_arr_t          corners;
    logic [COLOR_W-1:0]   color;
  } box_corners_t;

  localparam pos_t  POS_MAX    = pos_t'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam pos_t  POS_MIN    = pos_t'(-(64'sd1 <<< (POS_WIDTH - 1)));
  localparam rnd_t  RND_MAX    = rnd_t'(POS_MAX);
  localparam rnd_t  RND_MIN    = rnd_t'(POS_MIN);
  localparam sum_t  ROUND_HALF = sum_t'(1) <<< (AXIS_FRAC - 1);
  localparam edge_t LAST_EDGE  = edge_t'(NUM_EDGES - 1);

  // Drop the axis fraction bits with floor and clamp to the position range.
  // The half-LSB bias is already part of the sum.
  function automatic pos_t sat_round(input sum_t s);
    rnd_t r;
    pos_t res;
    r = rnd_t'(s >>> AXIS_FRAC);
    if (r > RND_MAX) begin
      res = POS_MAX;
    end else if (r < RND_MIN) begin
      res = POS_MIN;
    end else begin
      res = r[POS_WIDTH-1:0];
    end
    return res;
  endfunction

  // Start corner of each edge: bottom loop, top loop, then the sides.
  function automatic corner_idx_t edge_start(input edge_t e);
    corner_idx_t c;
    case (e)
      4'd0:    c = 3'd0;
      4'd1:    c = 3'd1;
      4'd2:    c = 3'd2;
      4'd3:    c = 3'd3;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd5;
      4'd6:    c = 3'd6;
      4'd7:    c = 3'd7;
      4'd8:    c = 3'd0;
      4'd9:    c = 3'd1;
      4'd10:   c = 3'd2;
      4'd11:   c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // End corner of each edge.
  function automatic corner_idx_t edge_end(input edge_t e);
    corner_idx_t c;
    case (e)
      4'd0:    c = 3'd1;
      4'd1:    c = 3'd2;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd0;
      4'd4:    c = 3'd5;
      4'd5:    c = 3'd6;
      4'd6:    c = 3'd7;
      4'd7:    c = 3'd4;
      4'd8:    c = 3'd4;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd6;
      4'd11:   c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/obbw_if.sv
`default_nettype none

// Box channel: one oriented box per item.
interface obbw_box_if;
  logic                            valid;
  logic                            ready;
  logic [obbw_pkg::POS_VEC_W-1:0]  box_center;
  logic [obbw_pkg::AXIS_VEC_W-1:0] axis_one;
  logic [obbw_pkg::AXIS_VEC_W-1:0] axis_two;
  logic [obbw_pkg::AXIS_VEC_W-1:0] axis_three;
  logic [obbw_pkg::POS_VEC_W-1:0]  half_extent;
  logic [obbw_pkg::COLOR_W-1:0]    line_color;

  modport source (
    output valid, box_center, axis_one, axis_two, axis_three, half_extent, line_color,
    input  ready
  );
  modport sink (
    input  valid, box_center, axis_one, axis_two, axis_three, half_extent, line_color,
    output ready
  );
endinterface

// Segment channel: one wireframe edge per item.
interface obbw_seg_if;
  logic                           valid;
  logic                           ready;
  logic [obbw_pkg::POS_VEC_W-1:0] seg_start;
  logic [obbw_pkg::POS_VEC_W-1:0] seg_end;
  logic [obbw_pkg::COLOR_W-1:0]   seg_color;
  logic [obbw_pkg::EDGE_W-1:0]    edge_number;
  logic                           last_edge;

  modport source (
    output valid, seg_start, seg_end, seg_color, edge_number, last_edge,
    input  ready
  );
  modport sink (
    input  valid, seg_start, seg_end, seg_color, edge_number, last_edge,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/obbw_corner_pipe.sv
`default_nettype none

module obbw_corner_pipe (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  obbw_box_if.sink                    box_i,
  output      logic                   valid_o,
  input  wire logic                   ready_i,
  output      obbw_pkg::box_corners_t corners_o
);
  import obbw_pkg::*;

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic en1, en2, en3;

  // Stage 1: nine axis-times-half-extent products.
  logic               v1_q;
  prod_t              prod_d [NUM_AXES][NUM_DIMS];
  prod_t              prod_q [NUM_AXES][NUM_DIMS];
  pos_t               ctr_d  [NUM_DIMS];
  pos_t               ctr_q  [NUM_DIMS];
  logic [COLOR_W-1:0] color1_q;

  // Stage 2: center plus the four sign pairs of axes one and two.
  logic               v2_q;
  sum_t               pair_d [NUM_DIMS][NUM_PAIRS];
  sum_t               pair_q [NUM_DIMS][NUM_PAIRS];
  prod_t              p3_q   [NUM_DIMS];
  logic [COLOR_W-1:0] color2_q;

  // Stage 3: the eight rounded and saturated corners.
  logic               v3_q;
  box_corners_t       set_d;
  box_corners_t       set_q;

  assign en3         = !v3_q || ready_i;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign box_i.ready = en1;
  assign valid_o     = v3_q;
  assign corners_o   = set_q;

  // Unpack the components and form the products.
  always_comb begin
    axis_t ax;
    pos_t  hv;
    for (int d = 0; d < NUM_DIMS; d++) begin
      ctr_d[d] = pos_t'(box_i.box_center[d*POS_WIDTH +: POS_WIDTH]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      hv = pos_t'(box_i.half_extent[i*POS_WIDTH +: POS_WIDTH]);
      for (int d = 0; d < NUM_DIMS; d++) begin
        case (i)
          0:       ax = axis_t'(box_i.axis_one[d*AXIS_WIDTH +: AXIS_WIDTH]);
          1:       ax = axis_t'(box_i.axis_two[d*AXIS_WIDTH +: AXIS_WIDTH]);
          default: ax = axis_t'(box_i.axis_three[d*AXIS_WIDTH +: AXIS_WIDTH]);
        endcase
        prod_d[i][d] = prod_t'(ax) * prod_t'(hv);
      end
    end
  end

  // Center with the rounding bias, plus or minus the first two products.
  always_comb begin
    sum_t base;
    sum_t t1;
    sum_t t2;
    for (int d = 0; d < NUM_DIMS; d++) begin
      base = (sum_t'(ctr_q[d]) <<< AXIS_FRAC) + ROUND_HALF;
      t1   = sum_t'(prod_q[0][d]);
      t2   = sum_t'(prod_q[1][d]);
      for (int m = 0; m < NUM_PAIRS; m++) begin
        pair_d[d][m] = base + (m[0] ? t1 : -t1) + (m[1] ? t2 : -t2);
      end
    end
  end

  // Add the third product and finish each corner component.
  always_comb begin
    logic [CORNER_IDX_W-1:0] kb;
    pair_idx_t               mi;
    sum_t                    t3;
    set_d.color = color2_q;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      kb = CORNER_IDX_W'(k);
      mi = {kb[1], kb[0] ^ kb[1]};
      for (int d = 0; d < NUM_DIMS; d++) begin
        t3 = sum_t'(p3_q[d]);
        set_d.corners[k][d*POS_WIDTH +: POS_WIDTH] =
          sat_round(pair_q[d][mi] + (kb[2] ? t3 : -t3));
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= box_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q   <= prod_d;
      ctr_q    <= ctr_d;
      color1_q <= box_i.line_color;
    end
    if (en2) begin
      pair_q   <= pair_d;
      color2_q <= color1_q;
      for (int d = 0; d < NUM_DIMS; d++) begin
        p3_q[d] <= prod_q[2][d];
      end
    end
    if (en3) begin
      set_q <= set_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/obb_wireframe_edges.sv
`default_nettype none

// Oriented box wireframe edge generator. Each box item on box_i yields twelve
// segment items on seg_o: edges 0-3 trace the bottom loop, 4-7 the top loop and
// 8-11 the side edges, and edge 11 carries last_edge. Corners are rounded to
// the Q10.10 position grid (halves toward plus infinity) and saturate on
// overflow. The block delivers one segment per cycle while seg_o.ready is high
// and a corner set is held; the edge sequencer walks the stored set edge by edge.
// Corners of the next box are computed in a three-stage pipeline while the
// current box is still being emitted, so consecutive boxes stream with no gap.
// When the sequencer is idle, an accepted box passes the three corner stages, the
// edge sequencer and the output register before its first segment is presented.
module obb_wireframe_edges (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  obbw_box_if.sink   box_i,
  obbw_seg_if.source seg_o
);
  import obbw_pkg::*;

  // Corner pipeline to edge sequencer.
  logic         cp_valid;
  logic         cp_ready;
  box_corners_t cp_set;

  // Edge sequencer.
  logic         e_valid_q;
  edge_t        e_cnt_q;
  box_corners_t e_set_q;
  logic         e_take;
  logic         e_done;

  // Output register.
  logic               o_valid_q;
  logic               o_en;
  corner_t            o_start_q;
  corner_t            o_end_q;
  logic [COLOR_W-1:0] o_color_q;
  edge_t              o_edge_q;
  logic               o_last_q;

  obbw_corner_pipe u_corner_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .box_i     (box_i),
    .valid_o   (cp_valid),
    .ready_i   (cp_ready),
    .corners_o (cp_set)
  );

  // Handshake between the sequencer and the output register.
  assign o_en     = !o_valid_q || seg_o.ready;
  assign e_take   = e_valid_q && o_en;
  assign e_done   = e_take && (e_cnt_q == LAST_EDGE);
  assign cp_ready = !e_valid_q || e_done;

  // Sequencer control: load a new corner set or step to the next edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      e_cnt_q   <= '0;
    end else if (cp_valid && cp_ready) begin
      e_valid_q <= 1'b1;
      e_cnt_q   <= '0;
    end else if (e_done) begin
      e_valid_q <= 1'b0;
    end else if (e_take) begin
      e_cnt_q <= e_cnt_q + edge_t'(1);
    end
  end

  // Corner set held for the duration of one box.
  always_ff @(posedge clk_i) begin
    if (cp_valid && cp_ready) begin
      e_set_q <= cp_set;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_en) begin
      o_valid_q <= e_valid_q;
    end
  end

  // Output payload: pick the two corners of the current edge.
  always_ff @(posedge clk_i) begin
    if (e_take) begin
      o_start_q <= e_set_q.corners[edge_start(e_cnt_q)];
      o_end_q   <= e_set_q.corners[edge_end(e_cnt_q)];
      o_color_q <= e_set_q.color;
      o_edge_q  <= e_cnt_q;
      o_last_q  <= (e_cnt_q == LAST_EDGE);
    end
  end

  assign seg_o.valid       = o_valid_q;
  assign seg_o.seg_start   = o_start_q;
  assign seg_o.seg_end     = o_end_q;
  assign seg_o.seg_color   = o_color_q;
  assign seg_o.edge_number = o_edge_q;
  assign seg_o.last_edge   = o_last_q;

endmodule

`default_nettype wire
